// ===== sv/cs_pkg.sv =====
// Shared types and constants for the comment stripper.
// Parse modes, character codes, register indexes and the emission record.
// No dependencies.
package cs_pkg;

    // Parser modes
    typedef enum logic [3:0] {
        MODE_CODE      = 4'd0,
        MODE_STRING    = 4'd1,
        MODE_CHAR      = 4'd2,
        MODE_SLASH     = 4'd3,
        MODE_SLSTAR    = 4'd4,
        MODE_LINE      = 4'd5,
        MODE_BLOCK     = 4'd6,
        MODE_JAVADOC   = 4'd7,
        MODE_HEADERDOC = 4'd8
    } t_mode;

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LINE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BLOCK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_JAVADOC   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_HEADERDOC = 2'd3;

    // Strip flags
    typedef struct packed {
        logic line;
        logic block;
        logic javadoc;
        logic headerdoc;
    } t_strip;

    // Bytes produced by one input item; data[0] goes out first
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
    } t_emit;

endpackage

// ===== sv/cs_parser.sv =====
// Comment stripper parser: mode and previous-byte state, strip flags,
// and the per-item emission logic. Depends on cs_pkg.
module cs_parser
    import cs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_wdata,
    output t_emit                o_emit
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_prev, n_prev;
    t_strip     r_strip;
    t_emit      em;

    // Next state and emitted bytes for the presented item
    always_comb begin
        n_mode = r_mode;
        n_prev = r_prev;
        em     = '0;
        if (i_end) begin
            // flush pending opener (slash-star only if block comments are kept), then closing newline
            if (r_mode == MODE_SLASH) begin
                em.data[0] = CH_SLASH;
                em.data[1] = CH_NL;
                em.cnt     = 2'd2;
            end else if (r_mode == MODE_SLSTAR) begin
                if (!r_strip.block) begin
                    em.data[0] = CH_SLASH;
                    em.data[1] = CH_STAR;
                    em.data[2] = CH_NL;
                    em.cnt     = 2'd3;
                end else begin
                    em.data[0] = CH_NL;
                    em.cnt     = 2'd1;
                end
            end else if (r_prev != CH_NL) begin
                em.data[0] = CH_NL;
                em.cnt     = 2'd1;
            end
            n_mode = MODE_CODE;
            n_prev = CH_NL;
        end else begin
            unique case (r_mode)
                MODE_STRING: begin
                    if (i_byte == CH_DQUOTE && r_prev != CH_BSLASH) n_mode = MODE_CODE;
                    em.data[0] = i_byte;
                    em.cnt     = 2'd1;
                end
                MODE_CHAR: begin
                    if (i_byte == CH_SQUOTE && r_prev != CH_BSLASH) n_mode = MODE_CODE;
                    em.data[0] = i_byte;
                    em.cnt     = 2'd1;
                end
                MODE_SLASH: begin
                    if (i_byte == CH_STAR) begin
                        n_mode = MODE_SLSTAR;
                    end else if (i_byte == CH_SLASH) begin
                        if (!r_strip.line) begin
                            em.data[0] = CH_SLASH;
                            em.data[1] = CH_SLASH;
                            em.cnt     = 2'd2;
                        end
                        n_mode = MODE_LINE;
                    end else begin
                        em.data[0] = CH_SLASH;
                        em.data[1] = i_byte;
                        em.cnt     = 2'd2;
                        if (i_byte == CH_DQUOTE)      n_mode = MODE_STRING;
                        else if (i_byte == CH_SQUOTE) n_mode = MODE_CHAR;
                        else                          n_mode = MODE_CODE;
                    end
                end
                MODE_SLSTAR: begin
                    // third byte picks the comment kind
                    if (i_byte == CH_STAR) begin
                        if (!r_strip.javadoc) begin
                            em.data = {CH_STAR, CH_STAR, CH_SLASH};
                            em.cnt  = 2'd3;
                        end
                        n_mode = MODE_JAVADOC;
                    end else if (i_byte == CH_BANG) begin
                        if (!r_strip.headerdoc) begin
                            em.data = {CH_BANG, CH_STAR, CH_SLASH};
                            em.cnt  = 2'd3;
                        end
                        n_mode = MODE_HEADERDOC;
                    end else begin
                        if (!r_strip.block) begin
                            em.data = {i_byte, CH_STAR, CH_SLASH};
                            em.cnt  = 2'd3;
                        end
                        n_mode = MODE_BLOCK;
                    end
                end
                MODE_LINE: begin
                    if (i_byte == CH_NL) begin
                        em.data[0] = CH_NL;
                        em.cnt     = 2'd1;
                        n_mode     = MODE_CODE;
                    end else if (!r_strip.line) begin
                        em.data[0] = i_byte;
                        em.cnt     = 2'd1;
                    end
                end
                MODE_BLOCK, MODE_JAVADOC, MODE_HEADERDOC: begin
                    if (!((r_mode == MODE_BLOCK     && r_strip.block)   ||
                          (r_mode == MODE_JAVADOC   && r_strip.javadoc) ||
                          (r_mode == MODE_HEADERDOC && r_strip.headerdoc))) begin
                        em.data[0] = i_byte;
                        em.cnt     = 2'd1;
                    end
                    if (r_prev == CH_STAR && i_byte == CH_SLASH) n_mode = MODE_CODE;
                end
                default: begin
                    // code mode
                    if (i_byte == CH_SLASH) begin
                        n_mode = MODE_SLASH;
                    end else begin
                        if (i_byte == CH_DQUOTE)      n_mode = MODE_STRING;
                        else if (i_byte == CH_SQUOTE) n_mode = MODE_CHAR;
                        else                          n_mode = MODE_CODE;
                        em.data[0] = i_byte;
                        em.cnt     = 2'd1;
                    end
                end
            endcase
            // the byte that fixes a plain block comment cannot close it
            if (n_mode == MODE_BLOCK && r_prev == CH_STAR && em.cnt == 2'd3)
                n_prev = CH_NUL;
            else
                n_prev = i_byte;
        end
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_CODE;
            r_prev  <= CH_NL;
            r_strip <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STRIP_LINE:      r_strip.line      <= i_cfg_wdata;
                    CFG_STRIP_BLOCK:     r_strip.block     <= i_cfg_wdata;
                    CFG_STRIP_JAVADOC:   r_strip.javadoc   <= i_cfg_wdata;
                    CFG_STRIP_HEADERDOC: r_strip.headerdoc <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_mode <= n_mode;
                r_prev <= n_prev;
            end
        end
    end

    assign o_emit = em;

    // End of text always returns the parser to code mode with previous byte newline
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end) |=> (r_mode == MODE_CODE && r_prev == CH_NL))
        else $error("parser not back in code mode after end of text");

    // Three bytes only come from a pending slash-star
    a_three_from_slstar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (em.cnt == 2'd3) |-> (r_mode == MODE_SLSTAR))
        else $error("three-byte emission outside slash-star mode");

    // A lone slash followed by an ordinary byte emits both
    a_lone_slash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_end && r_mode == MODE_SLASH && i_byte != CH_STAR &&
         i_byte != CH_SLASH) |-> (em.cnt == 2'd2 && em.data[0] == CH_SLASH))
        else $error("lone slash not emitted with its follower");

endmodule

// ===== sv/comment_stripper_top.sv =====
// Comment stripper top level: stream ports, parser and output byte buffer.
// Depends on cs_pkg and cs_parser.
// Latency: the first byte of an item is offered the cycle after its transfer.
// Throughput: one item per cycle while items yield at most one byte and the output
// is ready; an item yielding more bytes holds off the next until its last byte goes.
// Reset (synchronous, active low): code mode, previous byte newline, all strip
// flags 0, output empty; input ready once the run flag is set after release.
module comment_stripper_top
    import cs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [7:0] in_byte
    input  logic                 i_s_axis_tlast,   // end_of_text
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // [7:0] out_byte
    output logic                 o_m_axis_tlast,   // last_of_run
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_wdata
);

    logic            r_run;
    logic [1:0]      r_cnt, n_cnt;
    logic [2:0][7:0] r_buf, n_buf;
    logic            s_accept;
    logic            m_take;
    t_emit           emit;

    cs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_byte      (i_s_axis_tdata),
        .i_end       (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_emit      (emit)
    );

    // Handshakes: take a new item when the buffer is empty or drains this cycle
    assign m_take          = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = r_run && ((r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_axis_tready));
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Output buffer: load on input transfer, shift on output transfer
    always_comb begin
        n_cnt = r_cnt;
        n_buf = r_buf;
        if (s_accept) begin
            n_cnt = emit.cnt;
            n_buf = emit.data;
        end else if (m_take) begin
            n_cnt = r_cnt - 2'd1;
            n_buf = {CH_NUL, r_buf[2], r_buf[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_run <= 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_buf[0];
    assign o_m_axis_tlast  = (r_cnt == 2'd1);

    // Buffer count follows the emission of the item just taken
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_cnt == $past(emit.cnt)))
        else $error("buffer count does not match emission");

    // A pending byte moves to the head after each output transfer
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_take && r_cnt > 2'd1) |=> (o_m_axis_tvalid && o_m_axis_tdata == $past(r_buf[1])))
        else $error("pending output byte lost");

    // No input transfer while undelivered bytes would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && m_take)))
        else $error("input transfer overwrote pending output");

endmodule
